// ----- hw/rtl/ramr_pkg.sv -----
package ramr_pkg;

   localparam int unsigned WIDE_W = 64;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_CHECK,
      ST_GCD_START,
      ST_GCD_DIV,
      ST_GCD_NEXT,
      ST_QN_START,
      ST_QN_DIV,
      ST_QD_START,
      ST_QD_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

// ----- hw/rtl/ramr_divider.sv -----
module ramr_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ramr_pkg::WIDE_W-1:0]       dividend,
   input  logic [ramr_pkg::WIDE_W-1:0]       divisor,
   output ramr_pkg::div_ctl_type             ctl,
   output logic [ramr_pkg::WIDE_W-1:0]       quotient,
   output logic [ramr_pkg::WIDE_W-1:0]       remainder
);
   import ramr_pkg::*;

   localparam int unsigned CNT_W = $clog2(WIDE_W);

   logic [WIDE_W-1:0] quo_ff, quo_in;
   logic [WIDE_W-1:0] rem_ff, rem_in;
   logic [WIDE_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WIDE_W:0]   trial;
   logic [WIDE_W:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WIDE_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[WIDE_W]) begin
            rem_in = diff[WIDE_W-1:0];
            quo_in = {quo_ff[WIDE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDE_W-1:0];
            quo_in = {quo_ff[WIDE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WIDE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/rational_add_multiply_reduce_top.sv -----
// Rational add or multiply with reduction to lowest terms. One request is taken
// at a time; req_tready is low while it is worked on. Products are formed on a
// single 32x32 signed multiplier, one per cycle, then the gcd is found by
// Euclid's algorithm where each remainder uses one pass of a shared
// restoring divider, and two more passes divide numerator and denominator.
// Zero denominator, overflow and zero numerator skip the gcd and the divider
// passes and go from the check straight to the output state. The result
// sits in an output register until rsp_tready takes it.
module rational_add_multiply_reduce_top #(
   parameter int unsigned OPERAND_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // first_num, first_den, second_num, second_den
   input  logic         req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // result_num, result_den, zero pad
   output logic [1:0]   rsp_tuser   // status
);
   import ramr_pkg::*;

   localparam int unsigned OW = OPERAND_WIDTH;

   state_type state_ff, state_in;

   logic              mul_ff;
   logic signed [31:0] n1_ff, d1_ff, n2_ff, d2_ff;
   logic signed [63:0] p_ff, q_ff, den_ff;
   logic [WIDE_W-1:0] x_ff, y_ff, nm_ff, dm_ff;
   logic              neg_ff;
   logic signed [63:0] rnum_ff;
   logic [62:0]       rden_ff;
   status_type        stat_ff;
   logic              out_valid_ff;

   logic signed [31:0] ma, mb;
   logic signed [63:0] prod;
   logic signed [64:0] sum;
   logic [WIDE_W-1:0]  dvd, dvs, quo, rem;
   div_ctl_type        dctl;
   logic               dstart;

   function automatic logic signed [31:0] sext(input logic [31:0] v);
      logic [31:0] r;
      r = v;
      for (int i = 0; i < 32; i++) begin
         if (i >= OW) r[i] = v[OW-1];
      end
      return r;
   endfunction

   function automatic logic [63:0] mag(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   always_comb begin
      ma = n1_ff;
      mb = n2_ff;
      case (state_ff)
         ST_MUL1: begin ma = d1_ff; mb = d2_ff; end
         ST_MUL2: begin ma = n1_ff; mb = mul_ff ? n2_ff : d2_ff; end
         ST_MUL3: begin ma = n2_ff; mb = d1_ff; end
         default: begin ma = n1_ff; mb = n2_ff; end
      endcase
   end
   assign prod = ma * mb;
   assign sum  = {p_ff[63], p_ff} + {q_ff[63], q_ff};

   always_comb begin
      dvd = x_ff;
      dvs = y_ff;
      case (state_ff)
         ST_QN_START: begin dvd = nm_ff; dvs = x_ff; end
         ST_QD_START: begin dvd = dm_ff; dvs = x_ff; end
         default: begin dvd = x_ff; dvs = y_ff; end
      endcase
   end
   assign dstart = (state_ff == ST_GCD_START) || (state_ff == ST_QN_START) ||
                   (state_ff == ST_QD_START);

   ramr_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (dstart),
      .dividend  (dvd),
      .divisor   (dvs),
      .ctl       (dctl),
      .quotient  (quo),
      .remainder (rem)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_tvalid && !out_valid_ff) state_in = ST_MUL1;
         ST_MUL1:      state_in = ST_MUL2;
         ST_MUL2:      state_in = mul_ff ? ST_CHECK : ST_MUL3;
         ST_MUL3:      state_in = ST_CHECK;
         ST_CHECK: begin
            if (den_ff == 0 || (!mul_ff && (sum[64] != sum[63]))) state_in = ST_OUT;
            else if ((mul_ff ? p_ff : sum[63:0]) == 0) state_in = ST_OUT;
            else state_in = ST_GCD_NEXT;
         end
         ST_GCD_NEXT:  state_in = (y_ff == 0) ? ST_QN_START : ST_GCD_START;
         ST_GCD_START: state_in = ST_GCD_DIV;
         ST_GCD_DIV:   if (dctl.done) state_in = ST_GCD_NEXT;
         ST_QN_START:  state_in = ST_QN_DIV;
         ST_QN_DIV:    if (dctl.done) state_in = ST_QD_START;
         ST_QD_START:  state_in = ST_QD_DIV;
         ST_QD_DIV:    if (dctl.done) state_in = ST_OUT;
         ST_OUT:       state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE) && !out_valid_ff;
      rsp_tvalid = out_valid_ff;
      rsp_tdata  = {1'b0, rden_ff, rnum_ff};
      rsp_tuser  = stat_ff;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            mul_ff <= req_tuser;
            n1_ff  <= sext(req_tdata[31:0]);
            d1_ff  <= sext(req_tdata[63:32]);
            n2_ff  <= sext(req_tdata[95:64]);
            d2_ff  <= sext(req_tdata[127:96]);
         end
         ST_MUL1: den_ff <= prod;
         ST_MUL2: p_ff   <= prod;
         ST_MUL3: q_ff   <= prod;
         ST_CHECK: begin
            if (den_ff == 0) begin
               rnum_ff <= '0; rden_ff <= '0; stat_ff <= STATUS_ZERO_DEN;
            end else if (!mul_ff && (sum[64] != sum[63])) begin
               rnum_ff <= '0; rden_ff <= '0; stat_ff <= STATUS_OVERFLOW;
            end else begin
               rnum_ff <= '0; rden_ff <= 63'd1; stat_ff <= STATUS_OK;
            end
            x_ff   <= mag(mul_ff ? p_ff : sum[63:0]);
            nm_ff  <= mag(mul_ff ? p_ff : sum[63:0]);
            y_ff   <= mag(den_ff);
            dm_ff  <= mag(den_ff);
            neg_ff <= (mul_ff ? p_ff[63] : sum[63]) != den_ff[63];
         end
         ST_GCD_DIV: if (dctl.done) begin
            x_ff <= y_ff;
            y_ff <= rem;
         end
         ST_QN_DIV: if (dctl.done) rnum_ff <= neg_ff ? 64'(-quo) : quo;
         ST_QD_DIV: if (dctl.done) rden_ff <= quo[62:0];
         default: ;
      endcase
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE && !out_valid_ff))
      else $error("ready outside idle");
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |=> out_valid_ff)
      else $error("result not posted");
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && stat_ff == STATUS_OK) |-> (rden_ff != 0))
      else $error("zero denominator with ok status");

endmodule
